@@ design/jpvf_pkg.sv @@
// Shared widths, constants and limits for the joint position/velocity filter.
package jpvf_pkg;

  // Field widths of one update and one result
  localparam int JIDX_W = 4;
  localparam int POS_W  = 16;
  localparam int VEL_W  = 24;
  localparam int US_W   = 16;

  // Stream packing
  localparam int IN_TDATA_W   = 40;
  localparam int OUT_FIELDS_W = JIDX_W + POS_W + 2 * VEL_W;
  localparam int OUT_TDATA_W  = 72;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // Divider datapath: a rate numerator is |dpos| * 1e6 (36 bits), doubled plus divisor
  localparam int PROD_W = 36;
  localparam int NUM_W  = PROD_W + 1;
  localparam int DEN_W  = US_W;

  // 3*a + b + c of 24-bit values
  localparam int SMOOTH_SUM_W = VEL_W + 3;

  localparam logic [19:0]      RATE_SCALE = 20'd1000000;
  localparam logic [DEN_W-1:0] SMOOTH_DIV = 16'd5;

  // Quotient magnitudes beyond these saturate
  localparam logic [NUM_W-1:0] SAT_POS_LIM = 37'h00_007F_FFFF;
  localparam logic [NUM_W-1:0] SAT_NEG_LIM = 37'h00_0080_0000;

  localparam logic signed [VEL_W-1:0] VEL_MAX = 24'sh7F_FFFF;
  localparam logic signed [VEL_W-1:0] VEL_MIN = 24'sh80_0000;

endpackage

@@ design/jpvf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module jpvf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/jpvf_div.sv @@
// Bit-serial restoring divider: quo = floor((2*prod + den) / (2*den)), one bit per cycle.
module jpvf_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [jpvf_pkg::PROD_W-1:0]   prod,
  input  logic [jpvf_pkg::DEN_W-1:0]    den,
  output logic                          done,
  output logic [jpvf_pkg::NUM_W-1:0]    quo
);

  localparam int NUM_W = jpvf_pkg::NUM_W;
  localparam int REM_W = jpvf_pkg::DEN_W + 1;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [NUM_W-1:0] nq;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] dvs;
  logic [REM_W:0]   shifted;
  logic             fits;

  // Numerator bits leave at the top while quotient bits enter at the bottom
  assign shifted = {rem, nq[NUM_W-1]};
  assign fits    = shifted >= {1'b0, dvs};
  assign quo     = nq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        nq    <= {prod, 1'b0} + NUM_W'(den);
        rem   <= '0;
        dvs   <= {den, 1'b0};
        count <= CNT_W'(NUM_W);
        busy  <= 1'b1;
      end else if (busy) begin
        nq    <= {nq[NUM_W-2:0], fits};
        rem   <= fits ? REM_W'(shifted - {1'b0, dvs}) : shifted[REM_W-1:0];
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/joint_position_velocity_filter.sv @@
// Joint position/velocity filter top level: per-joint state, window memory and op sequencer.
// A skipped update (zero elapsed time or joint out of range) goes from acceptance straight to
// the finish step, which loads its result beat into the output register; a normal update makes
// five passes through the one-bit-per-cycle divider, each set up through sum, abs and multiply.
// Throughput: one update at a time, the next taken once the result sits in the output register.
// Reset: rst clears the sequencer and the per-joint valid bits, so every joint reads as zero.
module joint_position_velocity_filter #(
  parameter int JOINT_COUNT = 16,
  parameter int WINDOW_LEN  = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // joint_index[3:0], position_sample[19:4], elapsed_us[35:20], zero[39:36]
  input  logic [jpvf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // sample_fresh
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_joint[3:0], filtered_position[19:4], filtered_velocity[43:20],
  // averaged_velocity[67:44], zero[71:68]
  output logic [jpvf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // skipped
  output logic                                m_axis_tuser
);

  localparam int JIDX_W    = jpvf_pkg::JIDX_W;
  localparam int POS_W     = jpvf_pkg::POS_W;
  localparam int VEL_W     = jpvf_pkg::VEL_W;
  localparam int US_W      = jpvf_pkg::US_W;
  localparam int PROD_W    = jpvf_pkg::PROD_W;
  localparam int NUM_W     = jpvf_pkg::NUM_W;
  localparam int DEN_W     = jpvf_pkg::DEN_W;
  localparam int JA_W      = JOINT_COUNT > 1 ? $clog2(JOINT_COUNT) : 1;
  localparam int HEAD_W    = WINDOW_LEN > 1 ? $clog2(WINDOW_LEN) : 1;
  localparam int TOTAL_W   = VEL_W + $clog2(WINDOW_LEN);
  localparam int SUM_W     = TOTAL_W > jpvf_pkg::SMOOTH_SUM_W ? TOTAL_W
                                                                : jpvf_pkg::SMOOTH_SUM_W;
  localparam int WIN_DEPTH = JOINT_COUNT * WINDOW_LEN;
  localparam int WA_W      = WIN_DEPTH > 1 ? $clog2(WIN_DEPTH) : 1;

  typedef struct packed {
    logic [POS_W-1:0]   rp;
    logic [POS_W-1:0]   pp;
    logic [POS_W-1:0]   sp;
    logic [POS_W-1:0]   psp;
    logic [VEL_W-1:0]   rv;
    logic [VEL_W-1:0]   pv;
    logic [VEL_W-1:0]   sv;
    logic [TOTAL_W-1:0] total;
    logic [HEAD_W-1:0]  head;
    logic               wrapped;
  } joint_rec_t;

  localparam int REC_W = $bits(joint_rec_t);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_WIN, S_SUM, S_ABS, S_MUL, S_GO, S_WAIT, S_STORE, S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    OP_POS, OP_AVG, OP_VF, OP_VEL, OP_RV
  } op_t;

  state_t state;
  op_t    op;

  // Accepted update
  logic [JIDX_W-1:0]       joint;
  logic signed [POS_W-1:0] sample;
  logic                    fresh;
  logic [US_W-1:0]         us;
  logic                    skip;

  // Working copy of the joint's state
  logic signed [POS_W-1:0]   rp, pp, sp, psp;
  logic signed [VEL_W-1:0]   rv, pv, sv, vf, avg;
  logic signed [TOTAL_W-1:0] total;
  logic [HEAD_W-1:0]         head;
  logic                      wrapped;

  // Divider operand staging
  logic signed [SUM_W-1:0] num_s;
  logic                    neg;
  logic [SUM_W-1:0]        mag;
  logic [PROD_W-1:0]       prod;
  logic [DEN_W-1:0]        den;

  logic [JOINT_COUNT-1:0]  joint_valid;

  // Combinational helpers
  logic [JIDX_W-1:0]         in_joint;
  logic [US_W-1:0]           in_us;
  logic                      in_skip;
  logic [JA_W-1:0]           jaddr;
  logic [REC_W-1:0]          state_rdata;
  joint_rec_t                rec_rd;
  joint_rec_t                rec_wr;
  logic [HEAD_W-1:0]         head_sel;
  logic [WA_W-1:0]           win_addr;
  logic [VEL_W-1:0]          win_rdata;
  logic signed [VEL_W-1:0]   win_old;
  logic signed [TOTAL_W-1:0] total_next;
  logic                      head_last;
  logic [HEAD_W-1:0]         head_next;
  logic signed [SUM_W-1:0]   sum_next;
  logic [DEN_W-1:0]          den_next;
  logic                      rate_op;
  logic                      div_done;
  logic [NUM_W-1:0]          quo;
  logic signed [VEL_W-1:0]   res;
  logic signed [SUM_W-1:0]   rp_x, pp_x, sp_x, psp_x, pv_x, sv_x, vf_x;

  assign in_joint = s_axis_tdata[JIDX_W-1:0];
  assign in_us    = s_axis_tdata[JIDX_W+POS_W+US_W-1:JIDX_W+POS_W];
  assign in_skip  = (in_us == '0) || (7'(in_joint) >= 7'(JOINT_COUNT));

  assign s_axis_tready = (state == S_IDLE);
  assign jaddr         = JA_W'(joint);

  jpvf_ram #(
    .WIDTH (REC_W),
    .DEPTH (JOINT_COUNT)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (state == S_STORE),
    .wr_addr (jaddr),
    .wr_data (rec_wr),
    .rd_en   (state == S_IDLE),
    .rd_addr (JA_W'(in_joint)),
    .rd_data (state_rdata)
  );

  // A joint never written reads as all zero
  assign rec_rd = joint_valid[jaddr] ? joint_rec_t'(state_rdata) : '0;

  always_comb begin
    rec_wr         = '0;
    rec_wr.rp      = rp;
    rec_wr.pp      = pp;
    rec_wr.sp      = sp;
    rec_wr.psp     = psp;
    rec_wr.rv      = rv;
    rec_wr.pv      = pv;
    rec_wr.sv      = sv;
    rec_wr.total   = total;
    rec_wr.head    = head;
    rec_wr.wrapped = wrapped;
  end

  // Read the window slot with the head fresh out of the state RAM, write it with the register
  assign head_sel = (state == S_LOAD) ? rec_rd.head : head;
  assign win_addr = WA_W'(jaddr) * WA_W'(WINDOW_LEN) + WA_W'(head_sel);

  jpvf_ram #(
    .WIDTH (VEL_W),
    .DEPTH (WIN_DEPTH)
  ) u_window_ram (
    .clk     (clk),
    .wr_en   (state == S_WIN),
    .wr_addr (win_addr),
    .wr_data (rv),
    .rd_en   (state == S_LOAD),
    .rd_addr (win_addr),
    .rd_data (win_rdata)
  );

  // Slots fill in head order, so the slot at head holds data only once the ring has wrapped
  assign win_old    = wrapped ? $signed(win_rdata) : '0;
  assign total_next = total + TOTAL_W'(rv) - TOTAL_W'(win_old);
  assign head_last  = (head == HEAD_W'(WINDOW_LEN - 1));
  assign head_next  = head_last ? '0 : head + 1'b1;

  assign rp_x  = SUM_W'(rp);
  assign pp_x  = SUM_W'(pp);
  assign sp_x  = SUM_W'(sp);
  assign psp_x = SUM_W'(psp);
  assign pv_x  = SUM_W'(pv);
  assign sv_x  = SUM_W'(sv);
  assign vf_x  = SUM_W'(vf);

  assign rate_op = (op == OP_VF) || (op == OP_RV);

  always_comb begin
    unique case (op)
      OP_POS: begin
        sum_next = (sp_x <<< 1) + sp_x + pp_x + rp_x;
        den_next = jpvf_pkg::SMOOTH_DIV;
      end
      OP_AVG: begin
        sum_next = SUM_W'(total);
        den_next = DEN_W'(WINDOW_LEN);
      end
      OP_VF: begin
        sum_next = sp_x - psp_x;
        den_next = us;
      end
      OP_VEL: begin
        sum_next = (sv_x <<< 1) + sv_x + pv_x + vf_x;
        den_next = jpvf_pkg::SMOOTH_DIV;
      end
      OP_RV: begin
        sum_next = rp_x - pp_x;
        den_next = us;
      end
      default: begin
        sum_next = '0;
        den_next = jpvf_pkg::SMOOTH_DIV;
      end
    endcase
  end

  jpvf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_GO),
    .prod  (prod),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  // Apply sign and clamp to the velocity range
  always_comb begin
    if (!neg) begin
      res = (quo > jpvf_pkg::SAT_POS_LIM) ? jpvf_pkg::VEL_MAX : $signed(quo[VEL_W-1:0]);
    end else begin
      res = (quo > jpvf_pkg::SAT_NEG_LIM) ? jpvf_pkg::VEL_MIN : -$signed(quo[VEL_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      op            <= OP_POS;
      m_axis_tvalid <= 1'b0;
      joint_valid   <= '0;
    end else begin
      // Drop a taken beat unless the finish step loads the next one this cycle
      if (m_axis_tvalid && m_axis_tready && state != S_FINISH) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            joint  <= in_joint;
            sample <= s_axis_tdata[JIDX_W+POS_W-1:JIDX_W];
            fresh  <= s_axis_tuser;
            us     <= in_us;
            skip   <= in_skip;
            state  <= in_skip ? S_FINISH : S_LOAD;
          end
        end
        S_LOAD: begin
          if (fresh) begin
            pp  <= rec_rd.rp;
            psp <= rec_rd.sp;
            pv  <= rec_rd.rv;
            rp  <= sample;
          end else begin
            pp  <= rec_rd.pp;
            psp <= rec_rd.psp;
            pv  <= rec_rd.pv;
            rp  <= rec_rd.rp;
          end
          sp      <= rec_rd.sp;
          sv      <= rec_rd.sv;
          rv      <= rec_rd.rv;
          total   <= rec_rd.total;
          head    <= rec_rd.head;
          wrapped <= rec_rd.wrapped;
          state   <= S_WIN;
        end
        S_WIN: begin
          total   <= total_next;
          head    <= head_next;
          wrapped <= wrapped | head_last;
          op      <= OP_POS;
          state   <= S_SUM;
        end
        S_SUM: begin
          num_s <= sum_next;
          den   <= den_next;
          state <= S_ABS;
        end
        S_ABS: begin
          neg   <= num_s[SUM_W-1];
          mag   <= num_s[SUM_W-1] ? SUM_W'(-num_s) : SUM_W'(num_s);
          state <= S_MUL;
        end
        S_MUL: begin
          // A rate numerator is a position difference, at most 16 bits of magnitude
          prod  <= rate_op ? PROD_W'(mag[POS_W-1:0]) * PROD_W'(jpvf_pkg::RATE_SCALE)
                           : PROD_W'(mag);
          state <= S_GO;
        end
        S_GO: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            unique case (op)
              OP_POS: begin
                sp    <= res[POS_W-1:0];
                op    <= OP_AVG;
                state <= S_SUM;
              end
              OP_AVG: begin
                avg   <= res;
                op    <= OP_VF;
                state <= S_SUM;
              end
              OP_VF: begin
                vf    <= res;
                op    <= OP_VEL;
                state <= S_SUM;
              end
              OP_VEL: begin
                sv    <= res;
                op    <= OP_RV;
                state <= S_SUM;
              end
              OP_RV: begin
                rv    <= res;
                state <= S_STORE;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_STORE: begin
          joint_valid[jaddr] <= 1'b1;
          state              <= S_FINISH;
        end
        S_FINISH: begin
          // Hold until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= skip;
            if (skip) begin
              m_axis_tdata <= {{(jpvf_pkg::OUT_TDATA_W - JIDX_W){1'b0}}, joint};
            end else begin
              m_axis_tdata <= {{jpvf_pkg::OUT_PAD_W{1'b0}}, avg, sv, sp, joint};
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/jpvf_chk.sv @@
// Port-level checks for the joint position/velocity filter, bound to the top level.
module jpvf_chk #(
  parameter int JOINT_COUNT = 16
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [jpvf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tuser
);

  localparam int JIDX_W = jpvf_pkg::JIDX_W;

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // One update at a time: the input side closes right after a beat is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
      s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an update was still in flight");

  // A skipped result carries zero filter outputs
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid && m_axis_tuser |->
        m_axis_tdata[jpvf_pkg::OUT_FIELDS_W-1:JIDX_W] == '0)
    else $error("skipped result with nonzero filter fields");

  // A processed result always names a joint that has storage
  a_joint_range: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid && !m_axis_tuser |->
        7'(m_axis_tdata[JIDX_W-1:0]) < 7'(JOINT_COUNT))
    else $error("processed result for a joint out of range");

endmodule

bind joint_position_velocity_filter jpvf_chk #(.JOINT_COUNT(JOINT_COUNT)) u_jpvf_chk (.*);
